// ===== sv/fixed_block_free_list_allocator_macros.svh =====
// Assertion macros for the block pool allocator.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds in the same cycle as its trigger.
`define FBFL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fbfl assertion failed");

// Check that a condition holds in the cycle after its trigger.
`define FBFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fbfl assertion failed");

`else

`define FBFL_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define FBFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/fbfl_pkg.sv =====
`default_nettype none

package fbfl_pkg;

    // Field widths of the request and response payloads
    localparam int OP_W     = 1;
    localparam int BADDR_W  = 16;
    localparam int PAGE_W   = 4;
    localparam int RESULT_W = 16;
    localparam int LIVE_W   = 15;

    // Configuration register widths
    localparam int BB_W     = 12;
    localparam int ALIGN_W  = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Slot size needs one more bit than the block size (4095 rounds up to 4096)
    localparam int SLOT_W   = 13;

    // Link store geometry: one word per 4-byte address, 16384 words
    localparam int LINK_IDX_W = 14;
    localparam int LINK_WORDS = 16384;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LOG2  = 1'b1;

    // Register reset values
    localparam logic [BB_W-1:0]    BLOCK_BYTES_RST = 12'd16;
    localparam logic [ALIGN_W-1:0] ALIGN_LOG2_RST  = 4'd2;

    localparam logic [LIVE_W-1:0] LIVE_MAX = {LIVE_W{1'b1}};

    // Round the block size (at least one link word) up to the clamped alignment
    function automatic logic [SLOT_W-1:0] slot_bytes(
        input logic [BB_W-1:0]    block_bytes,
        input logic [ALIGN_W-1:0] align_log2
    );
        logic [SLOT_W-1:0]  size;
        logic [ALIGN_W-1:0] a;
        logic [SLOT_W-1:0]  mask;
        size = (block_bytes < BB_W'(4)) ? SLOT_W'(4) : SLOT_W'(block_bytes);
        if (align_log2 < ALIGN_W'(2))
            a = ALIGN_W'(2);
        else if (align_log2 > ALIGN_W'(11))
            a = ALIGN_W'(11);
        else
            a = align_log2;
        mask = (SLOT_W'(1) << a) - SLOT_W'(1);
        return (size + mask) & ~mask;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fbfl_intf.sv =====
`default_nettype none

// Request channel: one alloc or free per transfer
interface fbfl_req_if;
    logic                          valid;
    logic                          ready;
    logic [fbfl_pkg::OP_W-1:0]     operation;
    logic [fbfl_pkg::BADDR_W-1:0]  block_addr;
    logic [fbfl_pkg::PAGE_W-1:0]   page_index;

    modport source (output valid, output operation, output block_addr,
                    output page_index, input ready);
    modport sink   (input valid, input operation, input block_addr,
                    input page_index, output ready);
endinterface

// Response channel: one result per request
interface fbfl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fbfl_pkg::RESULT_W-1:0] result_addr;
    logic                          page_taken;
    logic                          status;
    logic [fbfl_pkg::LIVE_W-1:0]   live_count;

    modport source (output valid, output result_addr, output page_taken,
                    output status, output live_count, input ready);
    modport sink   (input valid, input result_addr, input page_taken,
                    input status, input live_count, output ready);
endinterface

`default_nettype wire

// ===== sv/fbfl_link_ram.sv =====
`default_nettype none

module fbfl_link_ram #(
    parameter int WIDTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            we,
    input  wire logic [fbfl_pkg::LINK_IDX_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]                wdata,
    input  wire logic [fbfl_pkg::LINK_IDX_W-1:0] raddr,
    output logic      [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem [fbfl_pkg::LINK_WORDS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/fixed_block_free_list_allocator.sv =====
// Fixed-size block pool with a LIFO free list kept in a link memory of 16384 words (one per
// 4-byte address) with one write port and one registered read port. A free goes from idle
// straight to the finish state that loads the result register, an alloc from a non-empty
// list passes through the pop state (one link read), and an alloc that finds the page too
// small goes from the setup state to finish. An alloc on an empty list carves the offered
// page first (setup, carve, read, pop, finish); the carve walks the page writing one link
// word per cycle for each of the PAGE_BYTES / slot - 1 blocks that the page yields. The
// request side is not ready until the sequencer is back in idle, and a result that cannot
// load because the previous one has not been taken holds the sequencer in finish. The
// link memory has no clearing pass; reading the link of a block never written is
// undefined. One result register decouples the response channel, so a new request is
// taken while a result waits.
`default_nettype none

`include "fixed_block_free_list_allocator_macros.svh"

module fixed_block_free_list_allocator #(
    parameter int PAGE_BYTES = 4096,
    parameter int ADDR_BITS  = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data,
    fbfl_req_if.sink                             req,
    fbfl_rsp_if.source                           rsp
);

    localparam int AW      = ADDR_BITS;
    localparam int XW      = (ADDR_BITS > 16) ? ADDR_BITS : 16;
    localparam int PB_BITS = $clog2(PAGE_BYTES + 1);
    localparam int EW      = ((PB_BITS > 14) ? PB_BITS : 14) + 1;
    localparam int BW      = $clog2(PAGE_BYTES) + fbfl_pkg::PAGE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_CARVE,
        S_RD,
        S_POP,
        S_FINISH
    } state_t;

    // Link word of an address: bits 15..2, higher bits ignored
    function automatic logic [fbfl_pkg::LINK_IDX_W-1:0] link_idx(input logic [AW-1:0] a);
        logic [XW-1:0] ext;
        ext = XW'(a);
        return ext[fbfl_pkg::LINK_IDX_W+1:2];
    endfunction

    state_t                           state_reg;
    logic [AW-1:0]                    head_reg;
    logic [AW-1:0]                    cur_reg;
    logic [AW-1:0]                    first_reg;
    logic [AW-1:0]                    res_addr_reg;
    logic                             res_taken_reg;
    logic                             res_status_reg;
    logic [fbfl_pkg::SLOT_W-1:0]      slot_reg;
    logic [EW-1:0]                    end_reg;
    logic [fbfl_pkg::PAGE_W-1:0]      page_reg;
    logic [fbfl_pkg::LIVE_W-1:0]      live_reg;
    logic [fbfl_pkg::BB_W-1:0]        bb_reg;
    logic [fbfl_pkg::ALIGN_W-1:0]     align_reg;

    logic                             out_valid_reg;
    logic [fbfl_pkg::RESULT_W-1:0]    out_addr_reg;
    logic                             out_taken_reg;
    logic                             out_status_reg;
    logic [fbfl_pkg::LIVE_W-1:0]      out_live_reg;

    logic                             accept;
    logic                             free_push;
    logic                             out_free;
    logic                             out_load;
    logic [AW-1:0]                    req_addr;
    logic [BW-1:0]                    base_full;
    logic [AW-1:0]                    base;
    logic [fbfl_pkg::SLOT_W:0]        slot2;
    logic [AW-1:0]                    cur_step;
    logic                             has_next;

    logic                             link_we;
    logic [fbfl_pkg::LINK_IDX_W-1:0]  link_waddr;
    logic [AW-1:0]                    link_wdata;
    logic [AW-1:0]                    link_rdata;

    // Handshake and address arithmetic
    assign accept    = req.valid && req.ready;
    assign free_push = accept && (req.operation == fbfl_pkg::OP_FREE) && (live_reg != '0);
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign out_load  = (state_reg == S_FINISH) && out_free;
    assign req_addr  = AW'(req.block_addr);
    assign base_full = BW'(page_reg) * BW'(PAGE_BYTES);
    assign base      = AW'(base_full);
    assign slot2     = {slot_reg, 1'b0};
    assign cur_step  = cur_reg + AW'(slot_reg);
    assign has_next  = (end_reg <= EW'(PAGE_BYTES));

    // Link memory write: push on free, chain slots during the carve
    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = link_idx(cur_reg);
        link_wdata = head_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                link_we    = free_push;
                link_waddr = link_idx(req_addr);
                link_wdata = head_reg;
            end
            S_CARVE:
            begin
                link_we    = 1'b1;
                link_waddr = link_idx(cur_reg);
                link_wdata = has_next ? cur_step : head_reg;
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    fbfl_link_ram #(
        .WIDTH (AW)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_idx(head_reg)),
        .rdata (link_rdata)
    );

    // Sequencer, list state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            cur_reg        <= '0;
            first_reg      <= '0;
            res_addr_reg   <= '0;
            res_taken_reg  <= 1'b0;
            res_status_reg <= fbfl_pkg::STATUS_OK;
            slot_reg       <= '0;
            end_reg        <= '0;
            page_reg       <= '0;
            live_reg       <= '0;
            bb_reg         <= fbfl_pkg::BLOCK_BYTES_RST;
            align_reg      <= fbfl_pkg::ALIGN_LOG2_RST;
            out_valid_reg  <= 1'b0;
            out_addr_reg   <= '0;
            out_taken_reg  <= 1'b0;
            out_status_reg <= fbfl_pkg::STATUS_OK;
            out_live_reg   <= '0;
        end
        else
        begin
            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fbfl_pkg::REG_BLOCK_BYTES: bb_reg    <= cfg_data;
                    fbfl_pkg::REG_ALIGN_LOG2:  align_reg <= cfg_data[fbfl_pkg::ALIGN_W-1:0];
                    default:                   bb_reg    <= bb_reg;
                endcase
            end

            // Drop the result once the response transfer completes and nothing new loads
            if (rsp.valid && rsp.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_addr_reg   <= '0;
                        res_taken_reg  <= 1'b0;
                        res_status_reg <= fbfl_pkg::STATUS_OK;
                        page_reg       <= req.page_index;
                        slot_reg       <= fbfl_pkg::slot_bytes(bb_reg, align_reg);
                        if (req.operation == fbfl_pkg::OP_FREE)
                        begin
                            if (live_reg == '0)
                            begin
                                res_status_reg <= fbfl_pkg::STATUS_IGNORED;
                            end
                            else
                            begin
                                head_reg <= req_addr;
                                live_reg <= live_reg - fbfl_pkg::LIVE_W'(1);
                            end
                            state_reg <= S_FINISH;
                        end
                        else if (head_reg != '0)
                        begin
                            state_reg <= S_POP;
                        end
                        else
                        begin
                            state_reg <= S_SETUP;
                        end
                    end
                end
                S_SETUP:
                begin
                    // Page must hold the header slot and at least one block
                    if (EW'(slot2) > EW'(PAGE_BYTES))
                    begin
                        res_status_reg <= fbfl_pkg::STATUS_IGNORED;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        cur_reg       <= base + AW'(slot_reg);
                        first_reg     <= base + AW'(slot_reg);
                        end_reg       <= EW'(slot2) + EW'(slot_reg);
                        res_taken_reg <= 1'b1;
                        state_reg     <= S_CARVE;
                    end
                end
                S_CARVE:
                begin
                    // Advance one slot per cycle; the last slot links to the old head
                    if (has_next)
                    begin
                        cur_reg <= cur_step;
                        end_reg <= end_reg + EW'(slot_reg);
                    end
                    else
                    begin
                        head_reg  <= first_reg;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    res_addr_reg <= head_reg;
                    head_reg     <= link_rdata;
                    if (live_reg != fbfl_pkg::LIVE_MAX)
                    begin
                        live_reg <= live_reg + fbfl_pkg::LIVE_W'(1);
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    // Hold until the result register is free
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_addr_reg   <= fbfl_pkg::RESULT_W'(res_addr_reg);
                        out_taken_reg  <= res_taken_reg;
                        out_status_reg <= res_status_reg;
                        out_live_reg   <= live_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_addr = out_addr_reg;
    assign rsp.page_taken  = out_taken_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.live_count  = out_live_reg;

    // Checks
    `FBFL_ASSERT_NEXT(a_free_dec, clk, rst_n, free_push, live_reg == $past(live_reg) - fbfl_pkg::LIVE_W'(1))
    `FBFL_ASSERT_NEXT(a_pop_head, clk, rst_n, state_reg == S_POP, head_reg == $past(link_rdata))
    `FBFL_ASSERT_NOW(a_ignored_zero, clk, rst_n, rsp.valid && (rsp.status == fbfl_pkg::STATUS_IGNORED), rsp.result_addr == '0)

endmodule

`default_nettype wire
